/* rtl/sha1_pkg.sv */
// shared types, constants and round functions for the sha-1 engine
// used by sha1_ctrl, sha1_dp and sha1_hash_engine_core; no dependencies
package sha1_pkg;

  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned STAGE_LEN   = 20;
  localparam int unsigned WIN_WORDS   = 16;
  localparam logic [5:0]  PAD_STOP    = 6'd56;
  localparam logic [5:0]  LAST_SLOT   = 6'd63;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef struct packed {
    logic       action;
    logic [7:0] message_byte;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1_out_t;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef enum logic [1:0] {
    STG_CH,
    STG_PAR0,
    STG_MAJ,
    STG_PAR1
  } stage_t;

  typedef struct packed {
    logic      absorb;
    byte_src_t src;
    logic [2:0] len_idx;
    logic      count_len;
    logic      init_rounds;
    logic      step;
    stage_t    stage;
    logic      fold;
    logic      load_out;
    logic [2:0] word_sel;
    logic      clear;
  } sha1_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sha1_stat_t;

  function automatic logic [31:0] sha1_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hefcdab89;
      3'd2:    v = 32'h98badcfe;
      3'd3:    v = 32'h10325476;
      default: v = 32'hc3d2e1f0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha1_k(input stage_t s);
    logic [31:0] v;
    case (s)
      STG_CH:   v = 32'h5a827999;
      STG_PAR0: v = 32'h6ed9eba1;
      STG_MAJ:  v = 32'h8f1bbcdc;
      default:  v = 32'hca62c1d6;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha1_f(input stage_t s, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    case (s)
      STG_CH:  v = (b & c) | (~b & d);
      STG_MAJ: v = (b & c) | (b & d) | (c & d);
      default: v = b ^ c ^ d;
    endcase
    return v;
  endfunction

endpackage

/* rtl/sha1_dp.sv */
// sha-1 datapath: message window, working variables, chaining words,
// bit counter and output register; driven by sha1_ctrl, uses sha1_pkg
module sha1_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1_pkg::sha1_cmd_t   cmd,
  input  logic [7:0]            message_byte,
  output sha1_pkg::sha1_stat_t  stat,
  output sha1_pkg::sha1_out_t   dig_data
);
  import sha1_pkg::*;

  logic [31:0] win [WIN_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [31:0] chain [NUM_WORDS];
  logic [5:0]  fill;
  logic [63:0] bit_len;

  logic [7:0]  byte_in;
  logic [31:0] t_sum;
  logic [31:0] w_new;

  always_comb begin
    case (cmd.src)
      SRC_MSG:  byte_in = message_byte;
      SRC_PAD:  byte_in = PAD_BYTE;
      SRC_LEN:  byte_in = bit_len[{~cmd.len_idx, 3'b000} +: 8];
      default:  byte_in = 8'h00;
    endcase
  end

  // one round: rotl5(a) + f + e + k + w
  assign t_sum = {a[26:0], a[31:27]} + sha1_f(cmd.stage, b, c, d) + e
                 + sha1_k(cmd.stage) + win[0];

  // schedule expansion over the sliding window
  always_comb begin
    logic [31:0] x;
    x = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {x[30:0], x[31]};
  end

  assign stat.fill = fill;

  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[WIN_WORDS-1] <= {win[WIN_WORDS-1][23:0], byte_in};
    end else if (cmd.step) begin
      for (int i = 0; i < WIN_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_WORDS-1] <= w_new;
    end

    if (cmd.init_rounds) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.step) begin
      a <= t_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end

    if (cmd.load_out) begin
      dig_data.digest_word <= chain[cmd.word_sel];
      dig_data.word_index  <= cmd.word_sel;
      dig_data.last_word   <= (cmd.word_sel == 3'(NUM_WORDS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= sha1_iv(3'(i));
      end
      fill    <= '0;
      bit_len <= '0;
    end else begin
      if (cmd.absorb) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_len) begin
        bit_len <= bit_len + BITS_PER_BYTE;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
    end
  end

endmodule

/* rtl/sha1_ctrl.sv */
// sha-1 controller: sequences absorb, padding, rounds, fold and digest output
// drives sha1_dp through sha1_cmd_t, uses sha1_pkg
module sha1_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  input  logic                  msg_action,
  output logic                  msg_stall,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  input  sha1_pkg::sha1_stat_t  stat,
  output sha1_pkg::sha1_cmd_t   cmd
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_ZERO,
    PH_LEN
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [6:0] rnd, rnd_next;
  logic [2:0] lidx, lidx_next;
  logic [2:0] widx, widx_next;
  logic       dig_valid_next;

  logic   last_byte;
  logic   load_ok;
  stage_t stage;

  assign last_byte = (stat.fill == LAST_SLOT);
  assign load_ok   = !dig_valid || !dig_stall;
  assign msg_stall = (state != S_IDLE);

  always_comb begin
    if (rnd < 7'(STAGE_LEN)) begin
      stage = STG_CH;
    end else if (rnd < 7'(2 * STAGE_LEN)) begin
      stage = STG_PAR0;
    end else if (rnd < 7'(3 * STAGE_LEN)) begin
      stage = STG_MAJ;
    end else begin
      stage = STG_PAR1;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    rnd_next       = rnd;
    lidx_next      = lidx;
    widx_next      = widx;
    dig_valid_next = dig_valid && dig_stall;

    cmd             = '0;
    cmd.src         = SRC_MSG;
    cmd.stage       = stage;
    cmd.len_idx     = lidx;
    cmd.word_sel    = widx;

    case (state)
      S_IDLE: begin
        if (msg_valid) begin
          cmd.absorb = 1'b1;
          if (!msg_action) begin
            cmd.src       = SRC_MSG;
            cmd.count_len = 1'b1;
          end else begin
            cmd.src    = SRC_PAD;
            phase_next = PH_ZERO;
            lidx_next  = '0;
          end
          if (last_byte) begin
            cmd.init_rounds = 1'b1;
            rnd_next        = '0;
            state_next      = S_ROUND;
          end else if (msg_action) begin
            state_next = S_FEED;
          end
        end
      end

      S_FEED: begin
        cmd.absorb = 1'b1;
        if (phase == PH_ZERO && stat.fill != PAD_STOP) begin
          cmd.src = SRC_ZERO;
        end else begin
          cmd.src    = SRC_LEN;
          lidx_next  = lidx + 3'd1;
          phase_next = PH_LEN;
        end
        if (last_byte) begin
          cmd.init_rounds = 1'b1;
          rnd_next        = '0;
          state_next      = S_ROUND;
        end
      end

      S_ROUND: begin
        cmd.step = 1'b1;
        if (rnd == 7'(ROUNDS - 1)) begin
          state_next = S_FOLD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end

      S_FOLD: begin
        cmd.fold = 1'b1;
        case (phase)
          PH_ZERO: state_next = S_FEED;
          PH_LEN: begin
            state_next = S_EMIT;
            widx_next  = '0;
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_EMIT: begin
        if (load_ok) begin
          cmd.load_out   = 1'b1;
          dig_valid_next = 1'b1;
          if (widx == 3'(NUM_WORDS - 1)) begin
            cmd.clear  = 1'b1;
            phase_next = PH_MSG;
            state_next = S_IDLE;
          end else begin
            widx_next = widx + 3'd1;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_MSG;
      rnd       <= '0;
      lidx      <= '0;
      widx      <= '0;
      dig_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      rnd       <= rnd_next;
      lidx      <= lidx_next;
      widx      <= widx_next;
      dig_valid <= dig_valid_next;
    end
  end

endmodule

/* rtl/sha1_hash_engine_core.sv */
// sha-1 engine top level: sha1_ctrl + sha1_dp, types from sha1_pkg
// absorb: one byte per cycle while the sequencer is idle; the 64th byte of a block
// starts 80 rounds on the single round unit, then one fold into the chaining words
// finish: one pad/length byte per cycle, a compression per filled block, then 5
// digest words, each held while dig_stall is high; synchronous rst
// restores the initial chaining words and clears the fill and bit counts
module sha1_hash_engine_core (
  input  logic                clk,
  input  logic                rst,
  // message side: one transaction absorbs a byte or finishes the message
  input  logic                msg_valid,
  output logic                msg_stall,
  input  sha1_pkg::sha1_in_t  msg_data,
  // digest side: five transactions per finished message, last one flagged
  output logic                dig_valid,
  input  logic                dig_stall,
  output sha1_pkg::sha1_out_t dig_data
);
  import sha1_pkg::*;

  // command and status between sequencer and datapath
  sha1_cmd_t  cmd;
  sha1_stat_t stat;

  // controller: new transactions only enter while the sequencer is idle;
  // a pending digest word in the output register does not block new input
  sha1_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_action (msg_data.action),
    .msg_stall  (msg_stall),
    .dig_valid  (dig_valid),
    .dig_stall  (dig_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: 16-word window shifts in bytes big-endian, then doubles as
  // the schedule during the rounds; output register holds one digest word
  sha1_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .message_byte (msg_data.message_byte),
    .stat         (stat),
    .dig_data     (dig_data)
  );

endmodule
